[rtl/core/assert_macros.svh]
// Assertion macros used by the top level RTL file of the stack pool block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASRT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASRT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spms_pkg.sv]
// Package with sizes, codes and memory request types of the stack pool block.
`timescale 1ns / 1ps
package spms_pkg;

  localparam int POOL_SLOTS  = 64;
  localparam int STACK_COUNT = 4;

  localparam int SLOT_W = $clog2(POOL_SLOTS);
  localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
  localparam int STK_W  = $clog2(STACK_COUNT);
  localparam int SEL_W  = 2;
  localparam int KEY_W  = 32;
  localparam int STS_W  = 2;

  localparam int IN_USER_W  = 1 + SEL_W;
  localparam int IN_DATA_W  = KEY_W;
  localparam int OUT_USER_W = STS_W;
  localparam int OUT_RAW_W  = KEY_W + SLOT_W + CNT_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_POP  = 1'b1;

  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [SLOT_W-1:0] wr_data;
  } link_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;
  } key_req_t;

endpackage

[rtl/core/spms_link_mem.sv]
// Link store: back links of all slots, with per-entry valid bits for the reset chain.
`timescale 1ns / 1ps
module spms_link_mem
  import spms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  link_req_t         req,
  output logic [SLOT_W-1:0] rd_data
);

  logic [SLOT_W-1:0]     mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] valid_r;
  logic [SLOT_W-1:0]     rd_data_r;
  logic [SLOT_W-1:0]     chain_val;

  // An entry never written holds its reset link: the slot just below it, wrapping at zero.
  always_comb begin
    if (req.rd_addr == '0) begin
      chain_val = SLOT_W'(POOL_SLOTS - 1);
    end else begin
      chain_val = req.rd_addr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : chain_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/spms_key_mem.sv]
// Key store: one key per pool slot, synchronous read.
`timescale 1ns / 1ps
module spms_key_mem
  import spms_pkg::*;
(
  input  logic             clk,
  input  key_req_t         req,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [POOL_SLOTS];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/spms_ctrl.sv]
// Sequencer: stack heads, counts, free list head and the result register.
`timescale 1ns / 1ps
module spms_ctrl
  import spms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  output link_req_t             link_req,
  input  logic [SLOT_W-1:0]     link_rd,
  output key_req_t              key_req,
  input  logic [KEY_W-1:0]      key_rd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0] stack_top_r  [STACK_COUNT];
  logic [SLOT_W-1:0] stack_top_nxt[STACK_COUNT];
  logic [CNT_W-1:0]  stack_size_r  [STACK_COUNT];
  logic [CNT_W-1:0]  stack_size_nxt[STACK_COUNT];
  logic [SLOT_W-1:0] free_top_r, free_top_nxt;
  logic [CNT_W-1:0]  free_size_r, free_size_nxt;

  logic             func_r;
  logic [STK_W-1:0] sel_r;
  logic [KEY_W-1:0] key_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic              in_fire, exec_fire, out_free;
  logic              cur_func;
  logic [STK_W-1:0]  in_idx, cur_idx;
  logic [SLOT_W-1:0] top_cur;
  logic [CNT_W-1:0]  size_cur;

  logic [STS_W-1:0]  res_status;
  logic [KEY_W-1:0]  res_key;
  logic [SLOT_W-1:0] res_slot;
  logic [CNT_W-1:0]  res_count;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign exec_fire = (state_r == S_EXEC) && out_free;

  assign in_idx   = STK_W'(in_tuser[SEL_W:1] % STACK_COUNT);
  assign cur_idx  = (state_r == S_IDLE) ? in_idx : sel_r;
  assign cur_func = (state_r == S_IDLE) ? in_tuser[0] : func_r;
  assign top_cur  = stack_top_r[cur_idx];
  assign size_cur = stack_size_r[cur_idx];

  always_comb begin
    state_nxt      = state_r;
    stack_top_nxt  = stack_top_r;
    stack_size_nxt = stack_size_r;
    free_top_nxt   = free_top_r;
    free_size_nxt  = free_size_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;

    // The read address is presented in the accept cycle and held while the result waits.
    link_req.rd_addr = (cur_func == FN_POP) ? top_cur : free_top_r;
    key_req.rd_addr  = top_cur;

    link_req.wr_en   = 1'b0;
    link_req.wr_addr = top_cur;
    link_req.wr_data = free_top_r;
    key_req.wr_en    = 1'b0;
    key_req.wr_addr  = free_top_r;
    key_req.wr_data  = key_r;

    res_status = ST_DONE;
    res_key    = '0;
    res_slot   = '0;
    res_count  = size_cur;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (func_r == FN_PUSH) begin
          if (free_size_r == '0) begin
            res_status = ST_FULL;
          end else begin
            res_slot               = free_top_r;
            free_top_nxt           = link_rd;
            free_size_nxt          = free_size_r - 1'b1;
            key_req.wr_en          = exec_fire;
            link_req.wr_en         = exec_fire;
            link_req.wr_addr       = free_top_r;
            link_req.wr_data       = top_cur;
            stack_top_nxt[sel_r]   = free_top_r;
            stack_size_nxt[sel_r]  = size_cur + 1'b1;
            res_count              = size_cur + 1'b1;
          end
        end else begin
          if (size_cur == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_slot              = top_cur;
            res_key               = key_rd;
            stack_top_nxt[sel_r]  = link_rd;
            stack_size_nxt[sel_r] = size_cur - 1'b1;
            res_count             = size_cur - 1'b1;
            link_req.wr_en        = exec_fire;
            free_top_nxt          = top_cur;
            free_size_nxt         = free_size_r + 1'b1;
          end
        end
        if (exec_fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_status;
          out_data_nxt  = OUT_DATA_W'({free_size_nxt, res_count, res_slot, res_key});
        end else begin
          // Result register still busy: keep all state until it drains.
          stack_top_nxt  = stack_top_r;
          stack_size_nxt = stack_size_r;
          free_top_nxt   = free_top_r;
          free_size_nxt  = free_size_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_top_r  <= SLOT_W'(POOL_SLOTS - 1);
      free_size_r <= CNT_W'(POOL_SLOTS);
      out_valid_r <= 1'b0;
      for (int i = 0; i < STACK_COUNT; i++) begin
        stack_top_r[i]  <= '0;
        stack_size_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      free_top_r   <= free_top_nxt;
      free_size_r  <= free_size_nxt;
      out_valid_r  <= out_valid_nxt;
      stack_top_r  <= stack_top_nxt;
      stack_size_r <= stack_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_tuser[0];
      sel_r  <= in_idx;
      key_r  <= in_tdata;
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/core/shared_pool_multi_stack.sv]
// Top level of the shared slot pool with several linked stacks.
//
//   Channel   Direction  Contents
//   in_*      slave      tuser: func, stack_select; tdata: push_key
//   out_*     master     tuser: status; tdata: popped_key, slot_used, stack_count, free_count
//
// An operation is accepted in S_IDLE, whose accept cycle reads the link and key memories;
// S_EXEC writes the link store, on a push the key store too, and loads the result register.
// Reset is synchronous; the link store's reset chain comes from valid bits cleared
// at once, so there is no clearing pass and an item is taken right after reset.
// While the result register is full and not taken, the operation waits in S_EXEC
// and no new transaction is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module shared_pool_multi_stack
  import spms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] push_key
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] func, [2:1] stack_select
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] popped_key, [37:32] slot_used,
                                            // [44:38] stack_count, [51:45] free_count
  output logic [OUT_USER_W-1:0] out_tuser   // [1:0] status
);

  link_req_t         link_req;
  key_req_t          key_req;
  logic [SLOT_W-1:0] link_rd;
  logic [KEY_W-1:0]  key_rd;

  spms_link_mem u_link_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (link_req),
    .rd_data (link_rd)
  );

  spms_key_mem u_key_mem (
    .clk     (clk),
    .req     (key_req),
    .rd_data (key_rd)
  );

  spms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .link_req   (link_req),
    .link_rd    (link_rd),
    .key_req    (key_req),
    .key_rd     (key_rd)
  );

  `ASRT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "second item accepted early")
  `ASRT_NOW(a_full_no_free, out_tvalid && out_tuser == ST_FULL, out_tdata[51:45] == '0, "pool full with free slots")
  `ASRT_NOW(a_empty_count, out_tvalid && out_tuser == ST_EMPTY, out_tdata[44:38] == '0, "empty status on nonempty stack")
  `ASRT_NOW(a_status_code, out_tvalid, out_tuser == ST_DONE || out_tuser == ST_FULL || out_tuser == ST_EMPTY, "bad status code")

endmodule

[test/tb_shared_pool_multi_stack.sv]
// Self-checking testbench for the shared slot pool with several linked stacks.
`timescale 1ns / 1ps
module tb_shared_pool_multi_stack;
  import spms_pkg::*;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  stk_cnt;
    logic [CNT_W-1:0]  free_cnt;
  } op_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [31:0] push_key
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] func, [2:1] stack_select
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [31:0] popped_key, [37:32] slot_used,
                                          // [44:38] stack_count, [51:45] free_count
  logic [OUT_USER_W-1:0] out_tuser;       // [1:0] status

  // Mirror of the pool: keys, links, stack heads and depths, free list.
  logic [KEY_W-1:0]  key_mem[POOL_SLOTS];
  logic [SLOT_W-1:0] next_link[POOL_SLOTS];
  logic [SLOT_W-1:0] stack_head[STACK_COUNT];
  logic [CNT_W-1:0]  stack_depth[STACK_COUNT];
  logic [SLOT_W-1:0] free_head;
  logic [CNT_W-1:0]  free_left;

  op_result_t pending_results[$];
  int         mismatches = 0;
  bit         steady = 1'b0;

  shared_pool_multi_stack dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #10 clk = ~clk;

  function automatic void pool_reset();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      key_mem[i] = '0;
      next_link[i] = (i == 0) ? SLOT_W'(POOL_SLOTS - 1) : SLOT_W'(i - 1);
    end
    for (int i = 0; i < STACK_COUNT; i++) begin
      stack_head[i] = '0;
      stack_depth[i] = '0;
    end
    free_head = SLOT_W'(POOL_SLOTS - 1);
    free_left = CNT_W'(POOL_SLOTS);
  endfunction

  function automatic op_result_t pool_apply(input logic fn, input logic [SEL_W-1:0] sel,
                                            input logic [KEY_W-1:0] key);
    op_result_t r;
    int s;
    logic [SLOT_W-1:0] slot;
    r = '0;
    s = int'(sel) % STACK_COUNT;
    if (fn == FN_PUSH) begin
      if (free_left == 0) begin
        r.status = ST_FULL;
      end else begin
        slot = free_head;
        free_head = next_link[slot];
        free_left = free_left - 1'b1;
        key_mem[slot] = key;
        next_link[slot] = stack_head[s];
        stack_head[s] = slot;
        stack_depth[s] = stack_depth[s] + 1'b1;
        r.status = ST_DONE;
        r.slot = slot;
      end
    end else begin
      if (stack_depth[s] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot = stack_head[s];
        r.key = key_mem[slot];
        stack_head[s] = next_link[slot];
        stack_depth[s] = stack_depth[s] - 1'b1;
        // The freed slot goes back on top of the free list.
        next_link[slot] = free_head;
        free_head = slot;
        free_left = free_left + 1'b1;
        r.status = ST_DONE;
        r.slot = slot;
      end
    end
    r.stk_cnt = stack_depth[s];
    r.free_cnt = free_left;
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 19))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Receiver: stalls now and then unless a steady stretch is running.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    op_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[KEY_W-1:0] !== want.key)
          report_mismatch("popped_key", out_tdata[KEY_W-1:0], want.key);
        if (out_tdata[KEY_W +: SLOT_W] !== want.slot)
          report_mismatch("slot_used", 32'(out_tdata[KEY_W +: SLOT_W]), 32'(want.slot));
        if (out_tdata[KEY_W+SLOT_W +: CNT_W] !== want.stk_cnt)
          report_mismatch("stack_count", 32'(out_tdata[KEY_W+SLOT_W +: CNT_W]),
                          32'(want.stk_cnt));
        if (out_tdata[KEY_W+SLOT_W+CNT_W +: CNT_W] !== want.free_cnt)
          report_mismatch("free_count", 32'(out_tdata[KEY_W+SLOT_W+CNT_W +: CNT_W]),
                          32'(want.free_cnt));
      end
    end
  end

  // Returns in the time step in which the transaction was accepted; valid stays
  // high so that a following call can present the next item without a gap.
  task automatic send_op(input logic fn, input logic [SEL_W-1:0] sel,
                         input logic [KEY_W-1:0] key);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {sel, fn};
    in_tdata <= key;
    pending_results.push_back(pool_apply(fn, sel, key));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    for (int s = 0; s < 4; s++) send_op(FN_POP, SEL_W'(s), $urandom);
    send_op(FN_PUSH, 2'd0, 32'h8000_0000);
    send_op(FN_PUSH, 2'd1, 32'h7FFF_FFFF);
    send_op(FN_PUSH, 2'd2, 32'h0000_0000);
    send_op(FN_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_op(FN_PUSH, 2'd0, 32'h5555_5555);
    send_op(FN_PUSH, 2'd0, 32'hAAAA_AAAA);
    // Stack 0 comes back in reverse order and then runs empty.
    repeat (4) send_op(FN_POP, 2'd0, $urandom);
    // A stack that was emptied must take a new head cleanly.
    send_op(FN_PUSH, 2'd0, 32'h1234_5678);
    send_op(FN_POP, 2'd0, 32'hFFFF_FFFF);
    for (int s = 1; s < 4; s++) send_op(FN_POP, SEL_W'(s), $urandom);
  endtask

  task automatic test_pool_full();
    while (free_left != 0) send_op(FN_PUSH, SEL_W'($urandom_range(0, 3)), pick_key());
    for (int s = 0; s < 4; s++) send_op(FN_PUSH, SEL_W'(s), pick_key());
    // Hold off until the full pool has answered every transaction.
    wait_drained();
    for (int s = 0; s < 4; s++) begin
      if (stack_depth[s] != 0) begin
        send_op(FN_POP, SEL_W'(s), $urandom);
        send_op(FN_PUSH, SEL_W'((s + 1) % 4), pick_key());
        send_op(FN_PUSH, SEL_W'(s), pick_key());
        break;
      end
    end
    for (int s = 0; s < 4; s++) begin
      while (stack_depth[s] != 0) send_op(FN_POP, SEL_W'(s), $urandom);
      send_op(FN_POP, SEL_W'(s), $urandom);
    end
  endtask

  task automatic test_random(input int n_ops, input int push_pct, input bit calm);
    steady = calm;
    repeat (n_ops) begin
      send_op(($urandom_range(0, 99) < push_pct) ? FN_PUSH : FN_POP,
              SEL_W'($urandom_range(0, 3)), pick_key());
    end
    steady = 1'b0;
  endtask

  initial begin
    pool_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pool_full();
    test_random(450, 50, 1'b0);
    test_random(450, 75, 1'b0);
    test_random(400, 25, 1'b0);
    test_random(400, 50, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
